// ===== sv/mdst_pkg.sv =====
// shared types, codes and constants of the drive state tracker
package mdst_pkg;

    // result buffer geometry
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    // request types
    localparam logic [1:0] REQ_MSG   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_FORCE = 2'd2;

    // message codes
    localparam logic [3:0] MSG_RUN     = 4'd0;
    localparam logic [3:0] MSG_STOP    = 4'd1;
    localparam logic [3:0] MSG_RESET   = 4'd2;
    localparam logic [3:0] MSG_CALL    = 4'd3;
    localparam logic [3:0] MSG_PROGRAM = 4'd4;
    localparam logic [3:0] MSG_PREPARE = 4'd5;
    localparam logic [3:0] MSG_IDLE    = 4'd6;
    localparam logic [3:0] MSG_CALCING = 4'd7;
    localparam logic [3:0] MSG_CALCEND = 4'd8;
    localparam logic [3:0] MSG_STANDBY = 4'd9;
    localparam logic [3:0] MSG_RUNNING = 4'd10;
    localparam logic [3:0] MSG_ERROR   = 4'd11;

    // reported state codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RUNREQ  = 4'd1;
    localparam logic [3:0] ST_PROGRAM = 4'd2;
    localparam logic [3:0] ST_CALCING = 4'd3;
    localparam logic [3:0] ST_CALCEND = 4'd4;
    localparam logic [3:0] ST_STANDBY = 4'd5;
    localparam logic [3:0] ST_PRERUN  = 4'd6;
    localparam logic [3:0] ST_RUNNING = 4'd7;
    localparam logic [3:0] ST_PRESTOP = 4'd8;

    // configuration register indexes
    localparam logic [2:0] CFG_POLL     = 3'd0;
    localparam logic [2:0] CFG_PREFETCH = 3'd1;
    localparam logic [2:0] CFG_PREPARE  = 3'd2;
    localparam logic [2:0] CFG_AXIS     = 3'd3;
    localparam logic [2:0] CFG_PAGE     = 3'd4;

    localparam logic [15:0] POLL_RESET     = 16'd500;
    localparam logic [15:0] PREFETCH_RESET = 16'd100;
    localparam logic [15:0] PREPARE_RESET  = 16'd5000;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_PREPARE = 3'd1,
        CMD_RUN     = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [15:0] poll_period;
        logic [15:0] prefetch_period;
        logic [15:0] prepare_period;
        logic [7:0]  axis_index;
        logic [3:0]  page_index;
    } t_cfg;

    typedef struct packed {
        t_cmd       cmd_kind;
        logic [7:0] cmd_axis;
        logic [3:0] cmd_page;
        logic [3:0] state_now;
        logic       run_requested;
        logic       prepare_fail;
        logic       last;
    } t_result;

    // num is 0 (nothing), 1 (r0) or 2 (r0 then r1)
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== sv/mdst_in_if.sv =====
// request channel: valid/ready handshake with the request fields
interface mdst_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] msg_code;
    logic [3:0] forced_state;
    logic       command_ok;

    modport source (
        output valid, req_type, msg_code, forced_state, command_ok,
        input  ready
    );
    modport sink (
        input  valid, req_type, msg_code, forced_state, command_ok,
        output ready
    );
endinterface

// ===== sv/mdst_out_if.sv =====
// result channel: valid/ready handshake with the result fields
interface mdst_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd_kind;
    logic [7:0] cmd_axis;
    logic [3:0] cmd_page;
    logic [3:0] state_now;
    logic       run_requested;
    logic       prepare_fail;
    logic       last;

    modport source (
        output valid, cmd_kind, cmd_axis, cmd_page, state_now, run_requested,
               prepare_fail, last,
        input  ready
    );
    modport sink (
        input  valid, cmd_kind, cmd_axis, cmd_page, state_now, run_requested,
               prepare_fail, last,
        output ready
    );
endinterface

// ===== sv/mdst_step.sv =====
// request register, tracker state registers and the single-pass step logic
module mdst_step import mdst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_space,
    mdst_in_if.sink i_in,
    output t_push o_push
);

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_RUNREQ  = 9'b000000010,
        M_PROGRAM = 9'b000000100,
        M_CALCING = 9'b000001000,
        M_CALCEND = 9'b000010000,
        M_STANDBY = 9'b000100000,
        M_PRERUN  = 9'b001000000,
        M_RUNNING = 9'b010000000,
        M_PRESTOP = 9'b100000000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic        run;
        logic        poll_act;
        logic [15:0] poll_rld;
        logic [15:0] poll_cnt;
        logic        prep_act;
        logic [15:0] prep_rld;
        logic [15:0] prep_cnt;
    } t_trk;

    typedef struct packed {
        t_trk       trk;
        t_cmd       cmd0;
        t_cmd       cmd1;
        logic [1:0] ncmd;
    } t_step;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] msg_code;
        logic [3:0] forced_state;
        logic       command_ok;
    } t_req;

    function automatic logic [3:0] f_mode_code(t_mode m);
        logic [3:0] c;
        case (m)
            M_IDLE:    c = ST_IDLE;
            M_RUNREQ:  c = ST_RUNREQ;
            M_PROGRAM: c = ST_PROGRAM;
            M_CALCING: c = ST_CALCING;
            M_CALCEND: c = ST_CALCEND;
            M_STANDBY: c = ST_STANDBY;
            M_PRERUN:  c = ST_PRERUN;
            M_RUNNING: c = ST_RUNNING;
            M_PRESTOP: c = ST_PRESTOP;
            default:   c = ST_IDLE;
        endcase
        return c;
    endfunction

    function automatic t_mode f_code_mode(logic [3:0] c);
        t_mode m;
        case (c)
            ST_IDLE:    m = M_IDLE;
            ST_RUNREQ:  m = M_RUNREQ;
            ST_PROGRAM: m = M_PROGRAM;
            ST_CALCING: m = M_CALCING;
            ST_CALCEND: m = M_CALCEND;
            ST_STANDBY: m = M_STANDBY;
            ST_PRERUN:  m = M_PRERUN;
            ST_RUNNING: m = M_RUNNING;
            ST_PRESTOP: m = M_PRESTOP;
            default:    m = M_IDLE;
        endcase
        return m;
    endfunction

    function automatic t_step f_issue(t_step s, t_cmd k);
        t_step r;
        r = s;
        case (s.ncmd)
            2'd0: begin
                r.cmd0 = k;
                r.ncmd = 2'd1;
            end
            2'd1: begin
                r.cmd1 = k;
                r.ncmd = 2'd2;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_step f_poll_start(t_step s, logic [15:0] p);
        t_step r;
        r = s;
        r.trk.poll_act = 1'b1;
        r.trk.poll_rld = p;
        r.trk.poll_cnt = p;
        return r;
    endfunction

    function automatic t_step f_prep_start(t_step s, logic [15:0] p);
        t_step r;
        r = s;
        r.trk.prep_act = 1'b1;
        r.trk.prep_rld = p;
        r.trk.prep_cnt = p;
        return r;
    endfunction

    // leaving calc end stops the prepare timer, leaving anything else the poll
    function automatic t_step f_exit(t_step s);
        t_step r;
        r = s;
        if (s.trk.mode == M_CALCEND) begin
            r.trk.prep_act = 1'b0;
        end else begin
            r.trk.poll_act = 1'b0;
        end
        return r;
    endfunction

    function automatic t_step f_set_idle(t_step s);
        t_step r;
        r = f_exit(s);
        r.trk.mode     = M_IDLE;
        r.trk.run      = 1'b0;
        r.trk.poll_act = 1'b0;
        return r;
    endfunction

    function automatic t_step f_go(t_step s, t_mode d, logic ok, t_cfg c);
        t_step r;
        r = f_exit(s);
        r.trk.mode = d;
        case (d)
            M_IDLE: begin
                r.trk.run      = 1'b0;
                r.trk.poll_act = 1'b0;
            end
            M_RUNREQ: begin
                r.trk.run = 1'b1;
            end
            M_CALCEND: begin
                r.trk.poll_act = 1'b0;
                if (r.trk.run) begin
                    r = f_issue(r, CMD_PREPARE);
                    if (!ok) begin
                        r = f_set_idle(r);
                    end else begin
                        r = f_poll_start(r, c.prefetch_period);
                        r = f_prep_start(r, c.prepare_period);
                    end
                end
            end
            M_STANDBY: begin
                r.trk.poll_act = 1'b0;
                if (r.trk.run) begin
                    r.trk.run = 1'b0;
                    r = f_issue(r, CMD_RUN);
                    if (!ok) begin
                        r = f_set_idle(r);
                    end else begin
                        r = f_exit(r);
                        r.trk.mode = M_PRERUN;
                    end
                    // poll restarts even when the run was refused
                    r = f_poll_start(r, c.poll_period);
                end
            end
            default: begin
                r = f_poll_start(r, c.poll_period);
            end
        endcase
        return r;
    endfunction

    function automatic t_step f_status(t_step s, logic [3:0] m, logic ok, t_cfg c);
        t_step r;
        r = s;
        if (m == MSG_PROGRAM) begin
            r = f_go(s, M_PROGRAM, ok, c);
        end else if (m == MSG_CALCING) begin
            r = f_go(s, M_CALCING, ok, c);
        end else if (m == MSG_STANDBY) begin
            r = f_go(s, M_STANDBY, ok, c);
        end else if (m == MSG_RUNNING) begin
            r = f_go(s, M_RUNNING, ok, c);
        end
        return r;
    endfunction

    function automatic t_step f_msg(t_step s, logic [3:0] m, logic ok, t_cfg c);
        t_step r;
        logic  to_idle;
        r = s;
        to_idle = (m == MSG_STOP) || (m == MSG_RESET) || (m == MSG_IDLE) ||
                  (m == MSG_ERROR);
        if (m <= MSG_ERROR) begin
            case (s.trk.mode)
                M_IDLE: begin
                    if (m == MSG_RUN || m == MSG_CALL) begin
                        r.trk.run = 1'b1;
                        r = f_go(r, M_CALCEND, ok, c);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_RUNREQ: begin
                    if (to_idle) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_CALL) begin
                        r.trk.run = 1'b1;
                        r = f_go(r, M_CALCEND, ok, c);
                    end else if (m == MSG_CALCEND) begin
                        r = f_go(r, M_CALCEND, ok, c);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_PROGRAM, M_CALCING: begin
                    if (m == MSG_RUN) begin
                        r.trk.run = 1'b1;
                    end else if (m == MSG_IDLE && s.trk.mode == M_PROGRAM) begin
                        r = s;
                    end else if (to_idle) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_CALCEND) begin
                        r = f_go(r, M_CALCEND, ok, c);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_CALCEND: begin
                    if (m == MSG_RUN || m == MSG_CALL) begin
                        r.trk.run = 1'b1;
                        r = f_poll_start(r, c.prefetch_period);
                        r = f_prep_start(r, c.prepare_period);
                        r = f_issue(r, CMD_PREPARE);
                    end else if (to_idle) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_PREPARE) begin
                        r = f_prep_start(r, c.prepare_period);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_STANDBY: begin
                    if (m == MSG_RUN) begin
                        r.trk.run = 1'b1;
                        r = f_issue(r, CMD_RUN);
                        r = f_go(r, ok ? M_PRERUN : M_IDLE, ok, c);
                    end else if (to_idle || m == MSG_CALCEND) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_STANDBY) begin
                        if (r.trk.run) begin
                            r.trk.run = 1'b0;
                            r = f_issue(r, CMD_RUN);
                        end
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_PRERUN: begin
                    if (m == MSG_STOP) begin
                        r = f_issue(r, CMD_STOP);
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (to_idle || m == MSG_CALCEND) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_STANDBY) begin
                        r = f_issue(r, CMD_RUN);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
                M_RUNNING: begin
                    if (m == MSG_STOP) begin
                        r = f_issue(r, CMD_STOP);
                        r = f_go(r, M_PRESTOP, ok, c);
                    end else if (m != MSG_RUNNING) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end
                end
                default: begin
                    // pre-stop
                    if (to_idle) begin
                        r = f_go(r, M_IDLE, ok, c);
                    end else if (m == MSG_CALCEND) begin
                        r = f_go(r, M_CALCEND, ok, c);
                    end else begin
                        r = f_status(r, m, ok, c);
                    end
                end
            endcase
        end
        return r;
    endfunction

    logic    r_in_vld;
    logic    n_in_vld;
    t_req    r_req;
    t_trk    r_trk;
    t_step   n_step;
    logic    acc;
    logic    fire;
    logic    poll_fire;
    logic    prep_fire;
    logic    fail;
    t_result res0;
    t_result res1;

    assign fire       = r_in_vld && i_space;
    assign i_in.ready = !r_in_vld || fire;
    assign acc        = i_in.valid && i_in.ready;
    assign n_in_vld   = acc || (r_in_vld && !fire);

    always_comb begin
        n_step.trk  = r_trk;
        n_step.cmd0 = CMD_NONE;
        n_step.cmd1 = CMD_NONE;
        n_step.ncmd = 2'd0;
        poll_fire   = 1'b0;
        prep_fire   = 1'b0;
        fail        = 1'b0;
        case (r_req.req_type)
            REQ_MSG: begin
                n_step = f_msg(n_step, r_req.msg_code, r_req.command_ok, i_cfg);
            end
            REQ_TICK: begin
                if (r_trk.poll_act) begin
                    if (r_trk.poll_cnt <= 16'd1) begin
                        n_step.trk.poll_cnt = r_trk.poll_rld;
                        poll_fire = 1'b1;
                    end else begin
                        n_step.trk.poll_cnt = r_trk.poll_cnt - 16'd1;
                    end
                end
                if (r_trk.prep_act) begin
                    if (r_trk.prep_cnt <= 16'd1) begin
                        n_step.trk.prep_cnt = r_trk.prep_rld;
                        prep_fire = 1'b1;
                    end else begin
                        n_step.trk.prep_cnt = r_trk.prep_cnt - 16'd1;
                    end
                end
                // query goes out ahead of a resent prepare
                if (poll_fire) begin
                    n_step = f_issue(n_step, CMD_QUERY);
                end
                if (prep_fire && r_trk.mode == M_CALCEND) begin
                    n_step = f_issue(n_step, CMD_PREPARE);
                    fail   = 1'b1;
                end
            end
            REQ_FORCE: begin
                if (r_req.forced_state <= ST_PRESTOP) begin
                    n_step.trk.mode = f_code_mode(r_req.forced_state);
                    if (r_req.forced_state != ST_IDLE &&
                        r_req.forced_state != ST_CALCEND) begin
                        n_step = f_poll_start(n_step, i_cfg.poll_period);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        res0.cmd_kind      = (n_step.ncmd == 2'd0) ? CMD_NONE : n_step.cmd0;
        res0.cmd_axis      = (res0.cmd_kind == CMD_NONE) ? 8'd0 : i_cfg.axis_index;
        res0.cmd_page      = (res0.cmd_kind == CMD_NONE) ? 4'd0 : i_cfg.page_index;
        res0.state_now     = f_mode_code(n_step.trk.mode);
        res0.run_requested = n_step.trk.run;
        res0.prepare_fail  = fail;
        res0.last          = (n_step.ncmd != 2'd2);

        res1.cmd_kind      = n_step.cmd1;
        res1.cmd_axis      = i_cfg.axis_index;
        res1.cmd_page      = i_cfg.page_index;
        res1.state_now     = res0.state_now;
        res1.run_requested = n_step.trk.run;
        res1.prepare_fail  = fail;
        res1.last          = 1'b1;

        o_push.r0  = res0;
        o_push.r1  = res1;
        if (!fire) begin
            o_push.num = 2'd0;
        end else if (n_step.ncmd == 2'd0) begin
            o_push.num = 2'd1;
        end else begin
            o_push.num = n_step.ncmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_trk    <= '{mode: M_IDLE, run: 1'b0, poll_act: 1'b0, poll_rld: 16'd0,
                          poll_cnt: 16'd0, prep_act: 1'b0, prep_rld: 16'd0,
                          prep_cnt: 16'd0};
        end else begin
            r_in_vld <= n_in_vld;
            if (fire) begin
                r_trk <= n_step.trk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req.req_type     <= i_in.req_type;
            r_req.msg_code     <= i_in.msg_code;
            r_req.forced_state <= i_in.forced_state;
            r_req.command_ok   <= i_in.command_ok;
        end
    end

endmodule

// ===== sv/mdst_res_fifo.sv =====
// result buffer: takes one or two results per cycle, hands out one
module mdst_res_fifo import mdst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_space,
    mdst_out_if.source o_out
);

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count;
    logic [RES_PTR_W-1:0]   n_wr_ptr;
    logic [RES_PTR_W-1:0]   n_rd_ptr;
    logic [RES_CNT_W-1:0]   n_count;
    logic [RES_PTR_W-1:0]   wr_ptr1;
    logic                   pop;
    t_result                rd;

    assign pop      = o_out.valid && o_out.ready;
    assign wr_ptr1  = r_wr_ptr + RES_PTR_W'(1);
    assign n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push.num);
    assign n_rd_ptr = r_rd_ptr + RES_PTR_W'(pop);
    assign n_count  = r_count + RES_CNT_W'(i_push.num) - RES_CNT_W'(pop);
    // room for a full pair regardless of the sink
    assign o_space  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign rd                  = r_mem[r_rd_ptr];
    assign o_out.valid         = (r_count != '0);
    assign o_out.cmd_kind      = rd.cmd_kind;
    assign o_out.cmd_axis      = rd.cmd_axis;
    assign o_out.cmd_page      = rd.cmd_page;
    assign o_out.state_now     = rd.state_now;
    assign o_out.run_requested = rd.run_requested;
    assign o_out.prepare_fail  = rd.prepare_fail;
    assign o_out.last          = rd.last;

endmodule

// ===== sv/motion_drive_state_tracker_top.sv =====
// top level: configuration registers, step stage and result buffer
// throughput: one request per cycle while each gives one result; a two-result tick is
//   buffered at once, and requests stall once more than two results wait unread
// reset: synchronous active low; state idle, timers stopped, registers to defaults,
//   result buffer empty
module motion_drive_state_tracker_top import mdst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    mdst_in_if.sink     i_in,
    mdst_out_if.source  o_out
);

    t_cfg  r_cfg;
    t_push push;
    logic  space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_period     <= POLL_RESET;
            r_cfg.prefetch_period <= PREFETCH_RESET;
            r_cfg.prepare_period  <= PREPARE_RESET;
            r_cfg.axis_index      <= 8'd0;
            r_cfg.page_index      <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL:     r_cfg.poll_period     <= i_cfg_data;
                CFG_PREFETCH: r_cfg.prefetch_period <= i_cfg_data;
                CFG_PREPARE:  r_cfg.prepare_period  <= i_cfg_data;
                CFG_AXIS:     r_cfg.axis_index      <= i_cfg_data[7:0];
                CFG_PAGE:     r_cfg.page_index      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    mdst_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_space (space),
        .i_in    (i_in),
        .o_push  (push)
    );

    mdst_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

    // an empty result carries no axis or page
    a_none_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.cmd_kind == CMD_NONE) |->
            (o_out.cmd_axis == 8'd0 && o_out.cmd_page == 4'd0))
        else $error("empty result carries axis or page");

    // prepare timeout is only reported from calc end
    a_fail_calcend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.prepare_fail) |-> (o_out.state_now == ST_CALCEND))
        else $error("prepare fail outside calc end");

    // only a command can be the first of a pair
    a_pair_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.cmd_kind != CMD_NONE))
        else $error("first of a pair carries no command");

    // the second of a pair is already buffered when the first leaves
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("second result of a pair missing");

endmodule

// ===== tb/sv/tb_motion_drive_state_tracker_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the drive state tracker: its own tracker copy predicts each result
module tb_motion_drive_state_tracker_top;
    import mdst_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         MAX_PRINTS = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    mdst_in_if  req_ch ();
    mdst_out_if res_ch ();

    motion_drive_state_tracker_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch),
        .o_out      (res_ch)
    );

    // tracker copy used for prediction
    t_cfg        trk_cfg;
    logic [3:0]  trk_state;
    logic        trk_run;
    logic        poll_on;
    logic [15:0] poll_reload;
    logic [15:0] poll_cnt;
    logic        prep_on;
    logic [15:0] prep_reload;
    logic [15:0] prep_cnt;
    logic        drive_ok;
    t_cmd        step_cmds[$];

    t_result     status_due[$];
    t_result     want;
    int          mismatches;
    int          items_sent;
    int          burst_left;
    int          rdy_mode;
    int          rdy_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 500000);
        $display("Mismatches found");
        $finish;
    end

    task automatic note_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- tracker

    function automatic void push_cmd(input t_cmd kind);
        if (step_cmds.size() < 2)
            step_cmds.push_back(kind);
    endfunction

    function automatic void start_poll(input logic [15:0] period);
        poll_on = 1'b1;
        poll_reload = period;
        poll_cnt = period;
    endfunction

    function automatic void start_prep();
        prep_on = 1'b1;
        prep_reload = trk_cfg.prepare_period;
        prep_cnt = trk_cfg.prepare_period;
    endfunction

    function automatic void leave_state(input logic [3:0] s);
        if (s == ST_CALCEND)
            prep_on = 1'b0;
        else
            poll_on = 1'b0;
    endfunction

    // exit actions of the old state, then entry actions of the new one
    function automatic void switch_state(input logic [3:0] s);
        leave_state(trk_state);
        trk_state = s;
        case (s)
            ST_IDLE: begin
                trk_run = 1'b0;
                poll_on = 1'b0;
            end
            ST_RUNREQ: begin
                trk_run = 1'b1;
            end
            ST_CALCEND: begin
                poll_on = 1'b0;
                if (trk_run) begin
                    push_cmd(CMD_PREPARE);
                    if (!drive_ok) begin
                        // refused prepare drops straight to idle
                        prep_on = 1'b0;
                        trk_state = ST_IDLE;
                        trk_run = 1'b0;
                        poll_on = 1'b0;
                    end else begin
                        start_poll(trk_cfg.prefetch_period);
                        start_prep();
                    end
                end
            end
            ST_STANDBY: begin
                poll_on = 1'b0;
                if (trk_run) begin
                    trk_run = 1'b0;
                    push_cmd(CMD_RUN);
                    trk_state = drive_ok ? ST_PRERUN : ST_IDLE;
                    // poll restarts whether the run was taken or not
                    start_poll(trk_cfg.poll_period);
                end
            end
            default: begin
                start_poll(trk_cfg.poll_period);
            end
        endcase
    endfunction

    function automatic void status_move(input logic [3:0] m);
        if (m == MSG_PROGRAM)
            switch_state(ST_PROGRAM);
        else if (m == MSG_CALCING)
            switch_state(ST_CALCING);
        else if (m == MSG_STANDBY)
            switch_state(ST_STANDBY);
        else if (m == MSG_RUNNING)
            switch_state(ST_RUNNING);
    endfunction

    function automatic void apply_msg(input logic [3:0] m);
        logic to_idle;
        to_idle = (m == MSG_STOP) || (m == MSG_RESET) || (m == MSG_IDLE) || (m == MSG_ERROR);
        if (m > MSG_ERROR)
            return;
        case (trk_state)
            ST_IDLE: begin
                if (m == MSG_RUN || m == MSG_CALL) begin
                    trk_run = 1'b1;
                    switch_state(ST_CALCEND);
                end else
                    status_move(m);
            end
            ST_RUNREQ: begin
                if (to_idle)
                    switch_state(ST_IDLE);
                else if (m == MSG_CALL) begin
                    trk_run = 1'b1;
                    switch_state(ST_CALCEND);
                end else if (m == MSG_CALCEND)
                    switch_state(ST_CALCEND);
                else
                    status_move(m);
            end
            ST_PROGRAM, ST_CALCING: begin
                if (m == MSG_RUN)
                    trk_run = 1'b1;
                else if (m == MSG_IDLE && trk_state == ST_PROGRAM) begin
                end else if (to_idle)
                    switch_state(ST_IDLE);
                else if (m == MSG_CALCEND)
                    switch_state(ST_CALCEND);
                else
                    status_move(m);
            end
            ST_CALCEND: begin
                if (m == MSG_RUN || m == MSG_CALL) begin
                    trk_run = 1'b1;
                    start_poll(trk_cfg.prefetch_period);
                    start_prep();
                    push_cmd(CMD_PREPARE);
                end else if (to_idle)
                    switch_state(ST_IDLE);
                else if (m == MSG_PREPARE)
                    start_prep();
                else
                    status_move(m);
            end
            ST_STANDBY: begin
                if (m == MSG_RUN) begin
                    trk_run = 1'b1;
                    push_cmd(CMD_RUN);
                    switch_state(drive_ok ? ST_PRERUN : ST_IDLE);
                end else if (to_idle || m == MSG_CALCEND)
                    switch_state(ST_IDLE);
                else if (m == MSG_STANDBY) begin
                    if (trk_run) begin
                        trk_run = 1'b0;
                        push_cmd(CMD_RUN);
                    end
                end else
                    status_move(m);
            end
            ST_PRERUN: begin
                if (m == MSG_STOP) begin
                    push_cmd(CMD_STOP);
                    switch_state(ST_IDLE);
                end else if (to_idle || m == MSG_CALCEND)
                    switch_state(ST_IDLE);
                else if (m == MSG_STANDBY)
                    push_cmd(CMD_RUN);
                else
                    status_move(m);
            end
            ST_RUNNING: begin
                if (m == MSG_STOP) begin
                    push_cmd(CMD_STOP);
                    switch_state(ST_PRESTOP);
                end else if (m == MSG_RUNNING) begin
                end else
                    switch_state(ST_IDLE);
            end
            default: begin
                if (to_idle)
                    switch_state(ST_IDLE);
                else if (m == MSG_CALCEND)
                    switch_state(ST_CALCEND);
                else
                    status_move(m);
            end
        endcase
    endfunction

    // one accepted transaction: update the tracker and queue its results
    function automatic void advance_tracker(input logic [1:0] req, input logic [3:0] msg,
                                            input logic [3:0] fst, input logic ok);
        logic    fail;
        logic    poll_fire;
        logic    prep_fire;
        int      n;
        t_result r;
        drive_ok = ok;
        step_cmds.delete();
        fail = 1'b0;
        poll_fire = 1'b0;
        prep_fire = 1'b0;
        case (req)
            REQ_MSG: apply_msg(msg);
            REQ_TICK: begin
                if (poll_on) begin
                    if (poll_cnt <= 16'd1) begin
                        poll_cnt = poll_reload;
                        poll_fire = 1'b1;
                    end else
                        poll_cnt = poll_cnt - 16'd1;
                end
                if (prep_on) begin
                    if (prep_cnt <= 16'd1) begin
                        prep_cnt = prep_reload;
                        prep_fire = 1'b1;
                    end else
                        prep_cnt = prep_cnt - 16'd1;
                end
                if (poll_fire)
                    push_cmd(CMD_QUERY);
                if (prep_fire && trk_state == ST_CALCEND) begin
                    push_cmd(CMD_PREPARE);
                    fail = 1'b1;
                end
            end
            REQ_FORCE: begin
                if (fst <= ST_PRESTOP) begin
                    trk_state = fst;
                    if (fst != ST_IDLE && fst != ST_CALCEND)
                        start_poll(trk_cfg.poll_period);
                end
            end
            default: begin
            end
        endcase
        n = (step_cmds.size() == 0) ? 1 : step_cmds.size();
        for (int k = 0; k < n; k++) begin
            r.cmd_kind      = (step_cmds.size() == 0) ? CMD_NONE : step_cmds[k];
            r.cmd_axis      = (r.cmd_kind == CMD_NONE) ? 8'd0 : trk_cfg.axis_index;
            r.cmd_page      = (r.cmd_kind == CMD_NONE) ? 4'd0 : trk_cfg.page_index;
            r.state_now     = trk_state;
            r.run_requested = trk_run;
            r.prepare_fail  = fail;
            r.last          = (k == n - 1);
            status_due.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_req(input logic [1:0] req, input logic [3:0] msg,
                            input logic [3:0] fst, input logic ok);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid        = 1'b1;
        req_ch.req_type     = req;
        req_ch.msg_code     = msg;
        req_ch.forced_state = fst;
        req_ch.command_ok   = ok;
        do @(posedge i_clk); while (!req_ch.ready);
        advance_tracker(req, msg, fst, ok);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_msg(input logic [3:0] msg, input logic ok);
        send_req(REQ_MSG, msg, 4'($urandom), ok);
    endtask

    task automatic send_force(input logic [3:0] fst);
        send_req(REQ_FORCE, 4'($urandom), fst, 1'($urandom));
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, 4'($urandom), 4'($urandom), 1'($urandom));
    endtask

    // lowers valid, waits until every due result came back, then settles
    task automatic wait_quiet(input int settle);
        int guard;
        guard = 0;
        req_ch.valid = 1'b0;
        while (status_due.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_POLL:     trk_cfg.poll_period     = data;
            CFG_PREFETCH: trk_cfg.prefetch_period = data;
            CFG_PREPARE:  trk_cfg.prepare_period  = data;
            CFG_AXIS:     trk_cfg.axis_index      = data[7:0];
            CFG_PAGE:     trk_cfg.page_index      = data[3:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] poll, input logic [15:0] prefetch,
                              input logic [15:0] prepare, input logic [7:0] axis,
                              input logic [3:0] page);
        write_reg(CFG_POLL, poll);
        write_reg(CFG_PREFETCH, prefetch);
        write_reg(CFG_PREPARE, prepare);
        write_reg(CFG_AXIS, {8'($urandom), axis});
        write_reg(CFG_PAGE, {12'($urandom), page});
        i_cfg_we = 1'b0;
    endtask

    // receiver: ready pattern switches between free flow, random and heavy stall
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_left = $urandom_range(10, 60);
            rdy_mode = $urandom_range(0, 2);
        end
        rdy_left--;
        case (rdy_mode)
            0:       res_ch.ready = 1'b1;
            1:       res_ch.ready = 1'($urandom);
            default: res_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
    end

    // checker: every result transaction against the oldest due result
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (status_due.size() == 0) begin
                note_mismatch($sformatf("result with nothing due: kind %0d state %0d",
                                        res_ch.cmd_kind, res_ch.state_now));
            end else begin
                want = status_due.pop_front();
                if (res_ch.cmd_kind !== want.cmd_kind)
                    note_mismatch($sformatf("cmd_kind got %0d want %0d",
                                            res_ch.cmd_kind, want.cmd_kind));
                if (res_ch.cmd_axis !== want.cmd_axis)
                    note_mismatch($sformatf("cmd_axis got %0d want %0d",
                                            res_ch.cmd_axis, want.cmd_axis));
                if (res_ch.cmd_page !== want.cmd_page)
                    note_mismatch($sformatf("cmd_page got %0d want %0d",
                                            res_ch.cmd_page, want.cmd_page));
                if (res_ch.state_now !== want.state_now)
                    note_mismatch($sformatf("state_now got %0d want %0d",
                                            res_ch.state_now, want.state_now));
                if (res_ch.run_requested !== want.run_requested)
                    note_mismatch($sformatf("run_requested got %0b want %0b",
                                            res_ch.run_requested, want.run_requested));
                if (res_ch.prepare_fail !== want.prepare_fail)
                    note_mismatch($sformatf("prepare_fail got %0b want %0b",
                                            res_ch.prepare_fail, want.prepare_fail));
                if (res_ch.last !== want.last)
                    note_mismatch($sformatf("last got %0b want %0b",
                                            res_ch.last, want.last));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        // default registers: prepare tagged with axis 0, page 0
        send_msg(MSG_RUN, 1'b1);
        send_tick();
        wait_quiet(4);
    endtask

    task automatic test_special_cases();
        send_req(REQ_UNUSED, 4'hF, 4'hF, 1'b1);
        send_msg(4'd13, 1'b1);
        send_force(4'd12);
        send_force(ST_IDLE);
        send_msg(MSG_RUN, 1'b0);            // refused prepare, back to idle
        send_msg(MSG_CALL, 1'b1);
        send_tick();
        send_tick();                        // poll and prepare both fire
        send_msg(MSG_PREPARE, 1'b1);
        send_msg(MSG_STANDBY, 1'b0);        // standby entry with run request, refused
        send_tick();                        // zero poll period fires every tick
        send_force(ST_CALCEND);
        send_tick();
        send_force(ST_PROGRAM);
        send_msg(MSG_IDLE, 1'b1);
        send_msg(MSG_PROGRAM, 1'b1);        // re-entry of the same state
        wait_quiet(4);
    endtask

    task automatic test_drive_cycle();
        send_force(ST_STANDBY);
        send_msg(MSG_RUN, 1'b1);
        send_msg(MSG_STANDBY, 1'b0);
        send_msg(MSG_RUNNING, 1'b1);
        send_msg(MSG_RUNNING, 1'b1);
        send_msg(MSG_STOP, 1'b0);
        send_msg(MSG_CALCEND, 1'b1);
        send_force(ST_RUNREQ);
        send_msg(MSG_CALL, 1'b1);
        send_force(ST_PRERUN);
        send_msg(MSG_STOP, 1'b0);
        wait_quiet(4);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            send_tick();
        else if (sel < 80)
            send_req(REQ_MSG, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                            : 4'($urandom_range(0, 11)),
                     4'($urandom), ($urandom_range(0, 4) != 0));
        else if (sel < 94)
            send_req(REQ_FORCE, 4'($urandom),
                     ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8)),
                     1'($urandom));
        else
            send_req(REQ_UNUSED, 4'($urandom), 4'($urandom), 1'($urandom));
    endtask

    // typical run, ticks between: start, prepare, standby, running, stop, idle/calcend/standby
    task automatic run_sequence();
        logic [3:0] steps[6];
        int         sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            send_force(ST_IDLE);
        else if (sel == 1)
            send_msg(MSG_RESET, 1'b1);
        steps[0] = $urandom_range(0, 1) ? MSG_RUN : MSG_CALL;
        steps[1] = MSG_PREPARE;
        steps[2] = MSG_STANDBY;
        steps[3] = MSG_RUNNING;
        steps[4] = MSG_STOP;
        sel = $urandom_range(0, 2);
        steps[5] = (sel == 0) ? MSG_IDLE : (sel == 1) ? MSG_CALCEND : MSG_STANDBY;
        for (int i = 0; i < 6; i++) begin
            repeat ($urandom_range(0, 4)) send_tick();
            if ($urandom_range(0, 9) == 0)
                random_item();
            else
                send_msg(steps[i], ($urandom_range(0, 6) != 0));
        end
    endtask

    task automatic test_random(input int count);
        int target;
        int pause_at;
        bit paused;
        target = items_sent + count;
        pause_at = items_sent + $urandom_range(count / 4, count / 2);
        paused = 1'b0;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) < 7)
                run_sequence();
            else
                repeat ($urandom_range(5, 15)) random_item();
            if (!paused && items_sent >= pause_at) begin
                // hold the sender until everything due has drained
                wait_quiet(0);
                paused = 1'b1;
            end
        end
        wait_quiet(4);
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_POLL;
        i_cfg_data          = 16'd0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_MSG;
        req_ch.msg_code     = MSG_RUN;
        req_ch.forced_state = ST_IDLE;
        req_ch.command_ok   = 1'b0;
        res_ch.ready        = 1'b0;
        mismatches          = 0;
        items_sent          = 0;
        burst_left          = 0;
        rdy_mode            = 0;
        rdy_left            = 0;
        trk_cfg             = '{POLL_RESET, PREFETCH_RESET, PREPARE_RESET, 8'd0, 4'd0};
        trk_state           = ST_IDLE;
        trk_run             = 1'b0;
        poll_on             = 1'b0;
        poll_reload         = 16'd0;
        poll_cnt            = 16'd0;
        prep_on             = 1'b0;
        prep_reload         = 16'd0;
        prep_cnt            = 16'd0;
        drive_ok            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        set_config(16'd0, 16'd1, 16'd2, 8'd255, 4'd15);
        test_special_cases();
        test_drive_cycle();

        set_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 30)), 8'($urandom), 4'($urandom));
        test_random(300);
        set_config(16'd1, 16'd1, 16'd1, 8'd0, 4'd0);
        test_random(200);
        set_config(16'd65535, 16'd65535, 16'd65535, 8'd255, 4'd15);
        test_random(150);
        set_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 30)), 8'($urandom), 4'($urandom));
        test_random(300);

        wait_quiet(8);
        if (status_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", status_due.size()));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
